// ===== rtl/core/ct_pkg.sv =====
// Shared types, token codes and helper functions for the C subset tokenizer.
`timescale 1ns / 1ps

package ct_pkg;

   localparam int MAX_IDENT_LEN = 63;
   localparam int POS_BITS      = 16;
   localparam int LEN_BITS      = 6;
   localparam int MAX_RES       = 4;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   typedef enum logic [4:0] {
      K_EOF   = 5'd0,  K_INT   = 5'd1,  K_IDENT = 5'd2,  K_KW_INT = 5'd3,
      K_VOID  = 5'd4,  K_RET   = 5'd5,  K_IF    = 5'd6,  K_ELSE   = 5'd7,
      K_WHILE = 5'd8,  K_PLUS  = 5'd9,  K_MINUS = 5'd10, K_STAR   = 5'd11,
      K_SLASH = 5'd12, K_PCT   = 5'd13, K_LPAR  = 5'd14, K_RPAR   = 5'd15,
      K_LBRC  = 5'd16, K_RBRC  = 5'd17, K_SEMI  = 5'd18, K_COMMA  = 5'd19,
      K_LT    = 5'd20, K_LE    = 5'd21, K_GT    = 5'd22, K_GE     = 5'd23,
      K_ASG   = 5'd24, K_EQ    = 5'd25, K_NOT   = 5'd26, K_NE     = 5'd27,
      K_AND   = 5'd28, K_OR    = 5'd29, K_ERR   = 5'd30, K_ICHAR  = 5'd31
   } kind_type;

   typedef enum logic [12:0] {
      M_IDLE  = 13'h0001, M_NUM  = 13'h0002, M_IDENT = 13'h0004,
      M_SLASH = 13'h0008, M_LCOM = 13'h0010, M_BCOM  = 13'h0020,
      M_BSTAR = 13'h0040, M_LT   = 13'h0080, M_GT    = 13'h0100,
      M_EQ    = 13'h0200, M_BANG = 13'h0400, M_AMP   = 13'h0800,
      M_PIPE  = 13'h1000
   } mode_type;

   typedef struct packed {
      kind_type              kind;
      logic [63:0]           value;
      logic [POS_BITS-1:0]   line;
      logic [POS_BITS-1:0]   col;
   } entry_type;

   typedef struct packed {
      entry_type [MAX_RES-1:0] ent;
      logic [2:0]              cnt;
   } group_type;

   // Match a finished identifier against the keyword list
   function automatic kind_type kw_kind(input logic [47:0] prefix, input logic too_long);
      kind_type k;
      k = K_IDENT;
      if (!too_long) begin
         case (prefix)
            48'h0000_0069_6E74: k = K_KW_INT;
            48'h0000_766F_6964: k = K_VOID;
            48'h7265_7475_726E: k = K_RET;
            48'h0000_0000_6966: k = K_IF;
            48'h0000_656C_7365: k = K_ELSE;
            48'h0077_6869_6C65: k = K_WHILE;
            default:            k = K_IDENT;
         endcase
      end
      return k;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

// ===== rtl/core/ct_scan.sv =====
// Scanner state registers and per-byte token logic.
`timescale 1ns / 1ps

module ct_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         source_byte,
   input  logic               end_of_source,
   output ct_pkg::group_type  group
);

   ct_pkg::mode_type                mode_ff, mode_in;
   logic [63:0]                     accum_ff, accum_in;
   logic [ct_pkg::LEN_BITS-1:0]     len_ff, len_in;
   logic [47:0]                     prefix_ff, prefix_in;
   logic                            toolong_ff, toolong_in;
   logic [ct_pkg::POS_BITS-1:0]     cline_ff, cline_in, ccol_ff, ccol_in;
   logic [ct_pkg::POS_BITS-1:0]     tline_ff, tline_in, tcol_ff, tcol_in;

   ct_pkg::group_type g;
   logic              do_start;
   logic [7:0]        c;
   ct_pkg::kind_type  single;

   // Work through one byte: earlier token, new token start, position, then end of source
   always_comb begin
      c          = source_byte;
      g          = '0;
      do_start   = 1'b0;
      single     = ct_pkg::K_ERR;
      mode_in    = mode_ff;
      accum_in   = accum_ff;
      len_in     = len_ff;
      prefix_in  = prefix_ff;
      toolong_in = toolong_ff;
      cline_in   = cline_ff;
      ccol_in    = ccol_ff;
      tline_in   = tline_ff;
      tcol_in    = tcol_ff;

      if (c != 8'd0) begin
         case (mode_ff)
            ct_pkg::M_NUM: begin
               if (ct_pkg::is_digit(c))
                  accum_in = (accum_ff << 3) + (accum_ff << 1) + {56'd0, c - "0"};
               else begin
                  g.ent[g.cnt[1:0]] = '{ct_pkg::K_INT, accum_ff, tline_ff, tcol_ff};
                  g.cnt = g.cnt + 3'd1;
                  do_start = 1'b1;
               end
            end
            ct_pkg::M_IDENT: begin
               if ((ct_pkg::is_alpha(c) || ct_pkg::is_digit(c)) &&
                   (len_ff < ct_pkg::LEN_BITS'(ct_pkg::MAX_IDENT_LEN))) begin
                  len_in = len_ff + 1'b1;
                  if (len_ff < ct_pkg::LEN_BITS'(6))
                     prefix_in = {prefix_ff[39:0], c};
                  else
                     toolong_in = 1'b1;
                  g.ent[g.cnt[1:0]] = '{ct_pkg::K_ICHAR, {56'd0, c}, tline_ff, tcol_ff};
                  g.cnt = g.cnt + 3'd1;
               end else begin
                  g.ent[g.cnt[1:0]] = '{ct_pkg::kw_kind(prefix_ff, toolong_ff), 64'd0,
                                        tline_ff, tcol_ff};
                  g.cnt = g.cnt + 3'd1;
                  do_start = 1'b1;
               end
            end
            ct_pkg::M_SLASH: begin
               if (c == "/") mode_in = ct_pkg::M_LCOM;
               else if (c == "*") mode_in = ct_pkg::M_BCOM;
               else begin
                  g.ent[g.cnt[1:0]] = '{ct_pkg::K_SLASH, 64'd0, tline_ff, tcol_ff};
                  g.cnt = g.cnt + 3'd1;
                  do_start = 1'b1;
               end
            end
            ct_pkg::M_LCOM: if (c == 8'd10) mode_in = ct_pkg::M_IDLE;
            ct_pkg::M_BCOM: if (c == "*") mode_in = ct_pkg::M_BSTAR;
            ct_pkg::M_BSTAR: begin
               if (c == "/") mode_in = ct_pkg::M_IDLE;
               else if (c != "*") mode_in = ct_pkg::M_BCOM;
            end
            ct_pkg::M_LT, ct_pkg::M_GT, ct_pkg::M_EQ, ct_pkg::M_BANG,
            ct_pkg::M_AMP, ct_pkg::M_PIPE: begin
               // Two-character operators: pair or fall back to the lone form
               logic [7:0]       second;
               ct_pkg::kind_type k1, k2;
               second = "=";
               k1 = ct_pkg::K_ERR;
               k2 = ct_pkg::K_ERR;
               case (mode_ff)
                  ct_pkg::M_LT:   begin k1 = ct_pkg::K_LT;  k2 = ct_pkg::K_LE; end
                  ct_pkg::M_GT:   begin k1 = ct_pkg::K_GT;  k2 = ct_pkg::K_GE; end
                  ct_pkg::M_EQ:   begin k1 = ct_pkg::K_ASG; k2 = ct_pkg::K_EQ; end
                  ct_pkg::M_BANG: begin k1 = ct_pkg::K_NOT; k2 = ct_pkg::K_NE; end
                  ct_pkg::M_AMP:  begin second = "&"; k2 = ct_pkg::K_AND; end
                  default:        begin second = "|"; k2 = ct_pkg::K_OR; end
               endcase
               if (c == second) begin
                  g.ent[g.cnt[1:0]] = '{k2, 64'd0, tline_ff, tcol_ff};
                  mode_in = ct_pkg::M_IDLE;
               end else begin
                  g.ent[g.cnt[1:0]] = '{k1, 64'd0, tline_ff, tcol_ff};
                  do_start = 1'b1;
               end
               g.cnt = g.cnt + 3'd1;
            end
            default: do_start = 1'b1;
         endcase

         // Start a new token at the current position
         if (do_start) begin
            tline_in = cline_ff;
            tcol_in  = ccol_ff;
            mode_in  = ct_pkg::M_IDLE;
            if (ct_pkg::is_space(c)) begin
               mode_in = ct_pkg::M_IDLE;
            end else if (ct_pkg::is_digit(c)) begin
               mode_in  = ct_pkg::M_NUM;
               accum_in = {56'd0, c - "0"};
            end else if (ct_pkg::is_alpha(c)) begin
               mode_in    = ct_pkg::M_IDENT;
               len_in     = ct_pkg::LEN_BITS'(1);
               prefix_in  = {40'd0, c};
               toolong_in = 1'b0;
               g.ent[g.cnt[1:0]] = '{ct_pkg::K_ICHAR, {56'd0, c}, cline_ff, ccol_ff};
               g.cnt = g.cnt + 3'd1;
            end else begin
               case (c)
                  "/": mode_in = ct_pkg::M_SLASH;
                  "<": mode_in = ct_pkg::M_LT;
                  ">": mode_in = ct_pkg::M_GT;
                  "=": mode_in = ct_pkg::M_EQ;
                  "!": mode_in = ct_pkg::M_BANG;
                  "&": mode_in = ct_pkg::M_AMP;
                  "|": mode_in = ct_pkg::M_PIPE;
                  default: begin
                     case (c)
                        "+":     single = ct_pkg::K_PLUS;
                        "-":     single = ct_pkg::K_MINUS;
                        "*":     single = ct_pkg::K_STAR;
                        "%":     single = ct_pkg::K_PCT;
                        "(":     single = ct_pkg::K_LPAR;
                        ")":     single = ct_pkg::K_RPAR;
                        "{":     single = ct_pkg::K_LBRC;
                        "}":     single = ct_pkg::K_RBRC;
                        ";":     single = ct_pkg::K_SEMI;
                        ",":     single = ct_pkg::K_COMMA;
                        default: single = ct_pkg::K_ERR;
                     endcase
                     g.ent[g.cnt[1:0]] = '{single, 64'd0, cline_ff, ccol_ff};
                     g.cnt = g.cnt + 3'd1;
                  end
               endcase
            end
         end

         // Advance the position, saturating
         if (c == 8'd10) begin
            if (cline_ff != ct_pkg::POS_MAX) cline_in = cline_ff + 1'b1;
            ccol_in = ct_pkg::POS_BITS'(1);
         end else if (ccol_ff != ct_pkg::POS_MAX) begin
            ccol_in = ccol_ff + 1'b1;
         end
      end

      // End of source: flush the pending token, emit EOF, return to reset
      if ((c == 8'd0) || end_of_source) begin
         case (mode_in)
            ct_pkg::M_NUM: begin
               g.ent[g.cnt[1:0]] = '{ct_pkg::K_INT, accum_in, tline_in, tcol_in};
               g.cnt = g.cnt + 3'd1;
            end
            ct_pkg::M_IDENT: begin
               g.ent[g.cnt[1:0]] = '{ct_pkg::kw_kind(prefix_in, toolong_in), 64'd0,
                                     tline_in, tcol_in};
               g.cnt = g.cnt + 3'd1;
            end
            ct_pkg::M_SLASH, ct_pkg::M_LT, ct_pkg::M_GT, ct_pkg::M_EQ,
            ct_pkg::M_BANG, ct_pkg::M_AMP, ct_pkg::M_PIPE: begin
               case (mode_in)
                  ct_pkg::M_SLASH: single = ct_pkg::K_SLASH;
                  ct_pkg::M_LT:    single = ct_pkg::K_LT;
                  ct_pkg::M_GT:    single = ct_pkg::K_GT;
                  ct_pkg::M_EQ:    single = ct_pkg::K_ASG;
                  ct_pkg::M_BANG:  single = ct_pkg::K_NOT;
                  default:         single = ct_pkg::K_ERR;
               endcase
               g.ent[g.cnt[1:0]] = '{single, 64'd0, tline_in, tcol_in};
               g.cnt = g.cnt + 3'd1;
            end
            default: ;
         endcase
         g.ent[g.cnt[1:0]] = '{ct_pkg::K_EOF, 64'd0, cline_in, ccol_in};
         g.cnt = g.cnt + 3'd1;
         mode_in    = ct_pkg::M_IDLE;
         accum_in   = '0;
         len_in     = '0;
         prefix_in  = '0;
         toolong_in = 1'b0;
         cline_in   = ct_pkg::POS_BITS'(1);
         ccol_in    = ct_pkg::POS_BITS'(1);
         tline_in   = ct_pkg::POS_BITS'(1);
         tcol_in    = ct_pkg::POS_BITS'(1);
      end
   end

   assign group = g;

   // Hold state; advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ct_pkg::M_IDLE;
         accum_ff   <= '0;
         len_ff     <= '0;
         prefix_ff  <= '0;
         toolong_ff <= 1'b0;
         cline_ff   <= ct_pkg::POS_BITS'(1);
         ccol_ff    <= ct_pkg::POS_BITS'(1);
         tline_ff   <= ct_pkg::POS_BITS'(1);
         tcol_ff    <= ct_pkg::POS_BITS'(1);
      end else if (fire) begin
         mode_ff    <= mode_in;
         accum_ff   <= accum_in;
         len_ff     <= len_in;
         prefix_ff  <= prefix_in;
         toolong_ff <= toolong_in;
         cline_ff   <= cline_in;
         ccol_ff    <= ccol_in;
         tline_ff   <= tline_in;
         tcol_ff    <= tcol_in;
      end
   end

endmodule

// ===== rtl/core/ct_outq.sv =====
// Result group register, drained one token per cycle while rsp_ready is high.
`timescale 1ns / 1ps

module ct_outq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  ct_pkg::group_type           group,
   output logic                        room,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ct_pkg::entry_type           head,
   output logic                        last
);

   ct_pkg::entry_type [ct_pkg::MAX_RES-1:0] ent_ff;
   logic [2:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign rsp_valid = (rem_ff != 3'd0);
   assign take      = rsp_valid && rsp_ready;
   assign room      = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ready);
   assign head      = ent_ff[idx_ff];
   assign last      = (rem_ff == 3'd1);

   // Load a new group or step to the next token
   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load && (group.cnt != 3'd0)) begin
         rem_in = group.cnt;
         idx_in = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && (group.cnt != 3'd0)) ent_ff <= group.ent;
   end

endmodule

// ===== rtl/core/c_subset_tokenizer.sv =====
// Top level of the C subset tokenizer.
// Tokens: a completed token is written to the output register when its byte is accepted.
// Input: one byte per cycle while each byte yields at most one token and rsp_ready
// is high; a byte yielding more tokens holds the input until the register drains.
// Reset (synchronous, active high): idle mode, position line 1 column 1,
// output register empty.
`timescale 1ns / 1ps

module c_subset_tokenizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_source_byte,
   input  logic         req_end_of_source,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [4:0]   rsp_token_kind,
   output logic [63:0]  rsp_token_value,
   output logic [15:0]  rsp_start_line,
   output logic [15:0]  rsp_start_col,
   output logic         rsp_last_of_item
);

   ct_pkg::group_type group;
   ct_pkg::entry_type head;
   logic              fire;

   assign fire = req_valid && req_ready;

   ct_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .source_byte   (req_source_byte),
      .end_of_source (req_end_of_source),
      .group         (group)
   );

   ct_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .group     (group),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head),
      .last      (rsp_last_of_item)
   );

   assign rsp_token_kind  = head.kind;
   assign rsp_token_value = head.value;
   assign rsp_start_line  = head.line;
   assign rsp_start_col   = head.col;

endmodule
